// ----- src/lesd_pkg.sv -----
// ----------------------------------------------------------------------------
// lesd_pkg
// Shared types and constants for the line edge sigma detector: payload
// structs, configuration struct, register indexes, command, phase and mode codes.
// ----------------------------------------------------------------------------
package lesd_pkg;

  localparam int unsigned SampleBits = 12;
  localparam int unsigned MaxCalib   = 255;
  localparam int unsigned CountBits  = 8;
  localparam int unsigned SigmaBits  = 10;
  localparam int unsigned DsqBits    = 2 * SampleBits;
  localparam int unsigned SumBits    = DsqBits + CountBits + 1;
  localparam int unsigned KkBits     = 2 * SigmaBits;
  localparam int unsigned ProdBits   = SumBits + KkBits;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgBits    = SigmaBits;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] RegCalibSamples = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegSigmaFactor  = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegPerSideMode  = 2'd2;

  // command codes
  localparam logic CmdStart  = 1'b0;
  localparam logic CmdSample = 1'b1;

  // phase codes
  localparam logic [1:0] PhCal  = 2'd0;
  localparam logic [1:0] PhDet  = 2'd1;
  localparam logic [1:0] PhDone = 2'd2;

  // mode codes
  localparam logic ModeBoth    = 1'b0;
  localparam logic ModePerSide = 1'b1;

  localparam logic [CountBits-1:0] CalibReset = 8'd10;
  localparam logic [SigmaBits-1:0] SigmaReset = 10'd400;

  typedef struct packed {
    logic                  cmd;
    logic [SampleBits-1:0] left_sample;
    logic [SampleBits-1:0] right_sample;
  } in_item_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       left_over;
    logic       right_over;
    logic       left_drive_on;
    logic       right_drive_on;
  } out_item_t;

  typedef struct packed {
    logic [CountBits-1:0] calib_samples;
    logic [SigmaBits-1:0] sigma_factor;
    logic                 per_side_mode;
  } cfg_t;

  function automatic logic [SampleBits-1:0] abs_diff(logic [SampleBits-1:0] a,
                                                     logic [SampleBits-1:0] b);
    logic [SampleBits-1:0] r;
    if (a >= b) r = a - b;
    else        r = b - a;
    return r;
  endfunction

  // calibration length clamped to one..MaxCalib
  function automatic logic [CountBits-1:0] eff_calib(logic [CountBits-1:0] n);
    logic [CountBits-1:0] r;
    r = n;
    if (r == '0) r = CountBits'(1);
    if (r > CountBits'(MaxCalib)) r = CountBits'(MaxCalib);
    return r;
  endfunction

endpackage

// ----- src/line_edge_sigma_detector_top.sv -----
// ----------------------------------------------------------------------------
// line_edge_sigma_detector_top
// Two-channel line edge detector with a sigma threshold on left and right
// sensor samples.
// ----------------------------------------------------------------------------
// Usage: items enter on in_valid_i/in_item_i and leave on out_valid_o/
// out_item_o; a side moves an item at a clock edge where its valid is high
// and its stall is low. Every input item gives exactly one result item.
// A start item (cmd 0) takes both baselines and enters calibration, the
// following calib_samples items build the squared-deviation sums, later
// items are tested against the threshold until the drives are stopped.
// The work per item is set by how many products the single shared
// multiplier must form in turn: none for start items and samples in the
// done phase, two in calibration, seven in detection. in_stall_o is high
// while an item is in work. The result register lets the next item be
// taken while the previous result waits; when out_stall_i holds, the
// finished item waits in its last step. Reset puts the block in the done
// phase with both drives off and loads calib_samples 10, sigma_factor 400
// and mode 0. Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i;
// the user must write it only while no item is in work, as the block does not enforce this.
// ----------------------------------------------------------------------------
module line_edge_sigma_detector_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  lesd_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output lesd_pkg::out_item_t               out_item_o,
  input  logic                              cfg_we_i,
  input  logic [lesd_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [lesd_pkg::CfgBits-1:0]      cfg_data_i
);

  lesd_pkg::cfg_t                 cfg_q;
  lesd_pkg::out_item_t            res;
  lesd_pkg::out_item_t            out_q;
  logic                           out_valid_q;
  logic                           busy;
  logic                           res_valid;
  logic                           res_ready;
  logic                           accept;
  logic [lesd_pkg::SumBits-1:0]   mul_a;
  logic [lesd_pkg::KkBits-1:0]    mul_b;
  logic [lesd_pkg::ProdBits-1:0]  prod;

  assign accept    = in_valid_i && !busy;
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{calib_samples: lesd_pkg::CalibReset,
                 sigma_factor:  lesd_pkg::SigmaReset,
                 per_side_mode: lesd_pkg::ModeBoth};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lesd_pkg::RegCalibSamples:
          cfg_q.calib_samples <= cfg_data_i[lesd_pkg::CountBits-1:0];
        lesd_pkg::RegSigmaFactor:
          cfg_q.sigma_factor <= cfg_data_i[lesd_pkg::SigmaBits-1:0];
        lesd_pkg::RegPerSideMode:
          cfg_q.per_side_mode <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  lesd_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  lesd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .item_i      (in_item_i),
    .cfg_i       (cfg_q),
    .res_ready_i (res_ready),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mul_a_o     (mul_a),
    .mul_b_o     (mul_b),
    .prod_i      (prod)
  );

  // output register, refilled from the result of the finishing item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) out_q <= res;
  end

  assign in_stall_o  = busy;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- src/lesd_mul.sv -----
// ----------------------------------------------------------------------------
// lesd_mul
// Shared unsigned multiplier with a registered product; the sequencer
// steers both operands and takes the product in the cycle after.
// ----------------------------------------------------------------------------
module lesd_mul (
  input  logic                          clk_i,
  input  logic [lesd_pkg::SumBits-1:0]  a_i,
  input  logic [lesd_pkg::KkBits-1:0]   b_i,
  output logic [lesd_pkg::ProdBits-1:0] prod_o
);

  logic [lesd_pkg::ProdBits-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= lesd_pkg::ProdBits'(a_i) * lesd_pkg::ProdBits'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// ----- src/lesd_ctrl.sv -----
// ----------------------------------------------------------------------------
// lesd_ctrl
// Sequencer and detector state: baselines, squared-deviation sums, sample
// count, phase and stop flags, all worked through the shared multiplier.
// ----------------------------------------------------------------------------
module lesd_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  lesd_pkg::in_item_t            item_i,
  input  lesd_pkg::cfg_t                cfg_i,
  input  logic                          res_ready_i,
  output logic                          busy_o,
  output logic                          res_valid_o,
  output lesd_pkg::out_item_t           res_o,
  output logic [lesd_pkg::SumBits-1:0]  mul_a_o,
  output logic [lesd_pkg::KkBits-1:0]   mul_b_o,
  input  logic [lesd_pkg::ProdBits-1:0] prod_i
);

  typedef enum logic [3:0] {
    StIdle, StFin, StCalL, StCalR, StCalFin,
    StKk, StDl, StRhsL, StLhsL, StDr, StRhsR, StLhsR, StDetFin
  } state_e;

  state_e                           state_q, state_d;
  lesd_pkg::in_item_t               item_q;
  logic [lesd_pkg::SampleBits-1:0]  base_l_q, base_r_q;
  logic [lesd_pkg::SumBits-1:0]     sum_l_q, sum_r_q;
  logic [lesd_pkg::CountBits-1:0]   count_q;
  logic [1:0]                       phase_q;
  logic                             stop_l_q, stop_r_q;
  logic [lesd_pkg::KkBits-1:0]      kk_q;
  logic [lesd_pkg::DsqBits-1:0]     dsq_q;
  logic [lesd_pkg::ProdBits-1:0]    rhs_q;
  logic                             over_l_q;

  logic [lesd_pkg::SampleBits-1:0]  dev_l, dev_r;
  logic [lesd_pkg::CountBits-1:0]   count_inc;
  logic                             over_r;
  logic                             stop_l_new, stop_r_new;

  assign dev_l     = lesd_pkg::abs_diff(item_q.left_sample, base_l_q);
  assign dev_r     = lesd_pkg::abs_diff(item_q.right_sample, base_r_q);
  assign count_inc = count_q + lesd_pkg::CountBits'(1);
  assign over_r    = prod_i > rhs_q;

  always_comb begin
    stop_l_new = stop_l_q;
    stop_r_new = stop_r_q;
    if (cfg_i.per_side_mode == lesd_pkg::ModeBoth) begin
      if (over_l_q || over_r) begin
        stop_l_new = 1'b1;
        stop_r_new = 1'b1;
      end
    end else begin
      if (over_l_q) stop_l_new = 1'b1;
      if (over_r)   stop_r_new = 1'b1;
    end
  end

  // operand steering for the shared multiplier
  always_comb begin
    mul_a_o = '0;
    mul_b_o = '0;
    unique case (state_q)
      StCalL, StDl: begin
        mul_a_o = lesd_pkg::SumBits'(dev_l);
        mul_b_o = lesd_pkg::KkBits'(dev_l);
      end
      StCalR, StCalFin, StDr: begin
        mul_a_o = lesd_pkg::SumBits'(dev_r);
        mul_b_o = lesd_pkg::KkBits'(dev_r);
      end
      StKk: begin
        mul_a_o = lesd_pkg::SumBits'(cfg_i.sigma_factor);
        mul_b_o = lesd_pkg::KkBits'(cfg_i.sigma_factor);
      end
      StRhsL: begin
        mul_a_o = sum_l_q;
        mul_b_o = kk_q;
      end
      StRhsR: begin
        mul_a_o = sum_r_q;
        mul_b_o = kk_q;
      end
      StLhsL, StLhsR, StDetFin: begin
        mul_a_o = lesd_pkg::SumBits'(dsq_q);
        mul_b_o = lesd_pkg::KkBits'(count_q);
      end
      default: begin
        mul_a_o = '0;
        mul_b_o = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          if (item_i.cmd == lesd_pkg::CmdStart || phase_q == lesd_pkg::PhDone) begin
            state_d = StFin;
          end else if (phase_q == lesd_pkg::PhCal) begin
            state_d = StCalL;
          end else begin
            state_d = StKk;
          end
        end
      end
      StCalL:   state_d = StCalR;
      StCalR:   state_d = StCalFin;
      StKk:     state_d = StDl;
      StDl:     state_d = StRhsL;
      StRhsL:   state_d = StLhsL;
      StLhsL:   state_d = StDr;
      StDr:     state_d = StRhsR;
      StRhsR:   state_d = StLhsR;
      StLhsR:   state_d = StDetFin;
      StFin, StCalFin, StDetFin: begin
        if (res_ready_i) state_d = StIdle;
      end
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      base_l_q    <= '0;
      base_r_q    <= '0;
      sum_l_q     <= '0;
      sum_r_q     <= '0;
      count_q     <= '0;
      phase_q     <= lesd_pkg::PhDone;
      stop_l_q    <= 1'b1;
      stop_r_q    <= 1'b1;
      res_valid_o <= 1'b0;
      res_o       <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_o <= 1'b0;
      unique case (state_q)
        StCalR: sum_l_q <= sum_l_q + lesd_pkg::SumBits'(prod_i);
        StFin: begin
          if (res_ready_i) begin
            res_valid_o <= 1'b1;
            if (item_q.cmd == lesd_pkg::CmdStart) begin
              base_l_q <= item_q.left_sample;
              base_r_q <= item_q.right_sample;
              sum_l_q  <= '0;
              sum_r_q  <= '0;
              count_q  <= '0;
              phase_q  <= lesd_pkg::PhCal;
              stop_l_q <= 1'b0;
              stop_r_q <= 1'b0;
              res_o    <= '{phase: lesd_pkg::PhCal, left_over: 1'b0, right_over: 1'b0,
                            left_drive_on: 1'b1, right_drive_on: 1'b1};
            end else begin
              res_o    <= '{phase: phase_q, left_over: 1'b0, right_over: 1'b0,
                            left_drive_on: !stop_l_q, right_drive_on: !stop_r_q};
            end
          end
        end
        StCalFin: begin
          if (res_ready_i) begin
            res_valid_o <= 1'b1;
            sum_r_q     <= sum_r_q + lesd_pkg::SumBits'(prod_i);
            count_q     <= count_inc;
            if (count_inc >= lesd_pkg::eff_calib(cfg_i.calib_samples)) begin
              phase_q <= lesd_pkg::PhDet;
              res_o   <= '{phase: lesd_pkg::PhDet, left_over: 1'b0, right_over: 1'b0,
                           left_drive_on: !stop_l_q, right_drive_on: !stop_r_q};
            end else begin
              res_o   <= '{phase: lesd_pkg::PhCal, left_over: 1'b0, right_over: 1'b0,
                           left_drive_on: !stop_l_q, right_drive_on: !stop_r_q};
            end
          end
        end
        StDetFin: begin
          if (res_ready_i) begin
            res_valid_o <= 1'b1;
            stop_l_q    <= stop_l_new;
            stop_r_q    <= stop_r_new;
            if (stop_l_new && stop_r_new) begin
              phase_q <= lesd_pkg::PhDone;
              res_o   <= '{phase: lesd_pkg::PhDone, left_over: over_l_q, right_over: over_r,
                           left_drive_on: !stop_l_new, right_drive_on: !stop_r_new};
            end else begin
              res_o   <= '{phase: lesd_pkg::PhDet, left_over: over_l_q, right_over: over_r,
                           left_drive_on: !stop_l_new, right_drive_on: !stop_r_new};
            end
          end
        end
        default: ;
      endcase
    end
  end

  // item capture and multiplier intermediates
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: if (start_i) item_q <= item_i;
      StDl:   kk_q  <= prod_i[lesd_pkg::KkBits-1:0];
      StRhsL: dsq_q <= prod_i[lesd_pkg::DsqBits-1:0];
      StLhsL: rhs_q <= prod_i;
      StDr:   over_l_q <= prod_i > rhs_q;
      StRhsR: dsq_q <= prod_i[lesd_pkg::DsqBits-1:0];
      StLhsR: rhs_q <= prod_i;
      default: ;
    endcase
  end

  assign busy_o = (state_q != StIdle);

endmodule
